// File: rtl/wsqc_pkg.sv
// ----------------------------------------------------------------------------
// wsqc_pkg
// Shared types and constants for the sliding-window symbol quota counter.
// ----------------------------------------------------------------------------
package wsqc_pkg;

  localparam int unsigned WINDOW_MAX_DEF = 64;
  localparam int unsigned SYM_W          = 3;
  localparam int unsigned CFG_W          = 7;
  localparam int unsigned HITS_W         = 16;
  localparam int unsigned REG_IDX_W      = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_WINDOW_LEN  = 3'd0,
    REG_FIRST_KIND  = 3'd1,
    REG_FIRST_MIN   = 3'd2,
    REG_SECOND_KIND = 3'd3,
    REG_SECOND_MIN  = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [CFG_W-1:0] window_len;
    logic [SYM_W-1:0] first_kind;
    logic [CFG_W-1:0] first_min;
    logic [SYM_W-1:0] second_kind;
    logic [CFG_W-1:0] second_min;
  } cfg_t;

endpackage

// File: rtl/window_symbol_quota_counter.sv
// ----------------------------------------------------------------------------
// window_symbol_quota_counter
// Counts windows of a stream of symbols in which two symbol kinds meet
// their configured minimum counts; reports the total on the last symbol.
// ----------------------------------------------------------------------------
// usage
//   input channel: symbol_i and last_i, transfer when in_valid_i is high
//   and in_stall_o is low; one symbol per cycle
//   output channel: window_hits_o, transfer when out_valid_o is high and
//   out_stall_i is low; one result per symbol that carries last_i
//   latency: the result appears in the cycle after its last symbol
//   throughput: one symbol per cycle while in_stall_o is low, set by the single
//   tally update between the symbol history read register and the state registers
//   stall: a held result stalls the input only while the receiver stalls
//   reset: config returns to window 1, first kind 0, second kind 1,
//   minimums 0; sequence state is cleared and no result is pending
//   config: write through cfg_we_i/cfg_idx_i/cfg_data_i while idle; a write
//   to a known register restarts the sequence
// ----------------------------------------------------------------------------
module window_symbol_quota_counter #(
  parameter int unsigned WINDOW_MAX = wsqc_pkg::WINDOW_MAX_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [wsqc_pkg::SYM_W-1:0]       symbol_i,
  input  logic                             last_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [wsqc_pkg::HITS_W-1:0]      window_hits_o,
  input  logic                             cfg_we_i,
  input  logic [wsqc_pkg::REG_IDX_W-1:0]   cfg_idx_i,
  input  logic [wsqc_pkg::CFG_W-1:0]       cfg_data_i
);
  import wsqc_pkg::*;

  localparam int unsigned LW = $clog2(WINDOW_MAX+1);
  localparam int unsigned CW = (LW > CFG_W) ? LW : CFG_W;

  cfg_t          cfg_q, cfg_d;
  logic          cfg_clear;
  logic [CW-1:0] len_ext;
  logic [LW-1:0] eff_len;
  logic          accept;
  logic [SYM_W-1:0] leave_sym;
  logic          out_valid;

  always_comb begin
    cfg_d     = cfg_q;
    cfg_clear = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_WINDOW_LEN: begin
          cfg_d.window_len = cfg_data_i;
          cfg_clear        = 1'b1;
        end
        REG_FIRST_KIND: begin
          cfg_d.first_kind = cfg_data_i[SYM_W-1:0];
          cfg_clear        = 1'b1;
        end
        REG_FIRST_MIN: begin
          cfg_d.first_min = cfg_data_i;
          cfg_clear       = 1'b1;
        end
        REG_SECOND_KIND: begin
          cfg_d.second_kind = cfg_data_i[SYM_W-1:0];
          cfg_clear         = 1'b1;
        end
        REG_SECOND_MIN: begin
          cfg_d.second_min = cfg_data_i;
          cfg_clear        = 1'b1;
        end
        default: begin
          cfg_clear = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_len  <= CFG_W'(1);
      cfg_q.first_kind  <= SYM_W'(0);
      cfg_q.first_min   <= '0;
      cfg_q.second_kind <= SYM_W'(1);
      cfg_q.second_min  <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // window length of zero acts as one, above the history depth as the depth
  always_comb begin
    len_ext = CW'(cfg_q.window_len);
    if (len_ext == '0) begin
      len_ext = CW'(1);
    end else if (len_ext > CW'(WINDOW_MAX)) begin
      len_ext = CW'(WINDOW_MAX);
    end
  end
  assign eff_len = len_ext[LW-1:0];

  assign in_stall_o = out_valid && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  wsqc_window #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .sym_i       (symbol_i),
    .len_i       (eff_len),
    .leave_sym_o (leave_sym)
  );

  wsqc_tally #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_tally (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .cfg_clear_i   (cfg_clear),
    .len_i         (eff_len),
    .accept_i      (accept),
    .sym_i         (symbol_i),
    .last_i        (last_i),
    .leave_sym_i   (leave_sym),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid),
    .window_hits_o (window_hits_o)
  );

  assign out_valid_o = out_valid;

endmodule

// File: rtl/wsqc_window.sv
// ----------------------------------------------------------------------------
// wsqc_window
// Circular symbol history; prefetches the symbol that leaves the window on
// the next transfer.
// ----------------------------------------------------------------------------
module wsqc_window #(
  parameter int unsigned WINDOW_MAX = wsqc_pkg::WINDOW_MAX_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               accept_i,
  input  logic [wsqc_pkg::SYM_W-1:0]         sym_i,
  input  logic [$clog2(WINDOW_MAX+1)-1:0]    len_i,
  output logic [wsqc_pkg::SYM_W-1:0]         leave_sym_o
);
  import wsqc_pkg::*;

  localparam int unsigned PW = $clog2(WINDOW_MAX);
  localparam int unsigned LW = $clog2(WINDOW_MAX+1);
  localparam int unsigned SW = LW + 1;

  logic [SYM_W-1:0] mem [WINDOW_MAX];
  logic [PW-1:0]    ptr_q, ptr_d;
  logic [SW-1:0]    sum;
  logic [SW-1:0]    wrapped;
  logic [PW-1:0]    rd_addr;
  logic [SYM_W-1:0] rd_data_q;
  logic             byp_q;
  logic [SYM_W-1:0] byp_sym_q;

  always_comb begin
    ptr_d = ptr_q;
    if (accept_i) begin
      if (ptr_q == PW'(WINDOW_MAX - 1)) begin
        ptr_d = '0;
      end else begin
        ptr_d = ptr_q + PW'(1);
      end
    end
  end

  // read address is next pointer minus window length, modulo depth
  assign sum     = SW'(ptr_d) + SW'(WINDOW_MAX) - SW'(len_i);
  assign wrapped = (sum >= SW'(WINDOW_MAX)) ? (sum - SW'(WINDOW_MAX)) : sum;
  assign rd_addr = wrapped[PW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
      byp_q <= 1'b0;
    end else begin
      ptr_q <= ptr_d;
      byp_q <= accept_i && (rd_addr == ptr_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      mem[ptr_q] <= sym_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[rd_addr];
    byp_sym_q <= sym_i;
  end

  assign leave_sym_o = byp_q ? byp_sym_q : rd_data_q;

endmodule

// File: rtl/wsqc_tally.sv
// ----------------------------------------------------------------------------
// wsqc_tally
// Window tallies, fill level, qualifying-window total and result register.
// ----------------------------------------------------------------------------
module wsqc_tally #(
  parameter int unsigned WINDOW_MAX = wsqc_pkg::WINDOW_MAX_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  wsqc_pkg::cfg_t                     cfg_i,
  input  logic                               cfg_clear_i,
  input  logic [$clog2(WINDOW_MAX+1)-1:0]    len_i,
  input  logic                               accept_i,
  input  logic [wsqc_pkg::SYM_W-1:0]         sym_i,
  input  logic                               last_i,
  input  logic [wsqc_pkg::SYM_W-1:0]         leave_sym_i,
  input  logic                               out_stall_i,
  output logic                               out_valid_o,
  output logic [wsqc_pkg::HITS_W-1:0]        window_hits_o
);
  import wsqc_pkg::*;

  localparam int unsigned LW = $clog2(WINDOW_MAX+1);
  localparam int unsigned CW = (LW > CFG_W) ? LW : CFG_W;

  logic [LW-1:0]     fill_q, fill_d, fill_n;
  logic [LW-1:0]     first_q, first_d, first_n;
  logic [LW-1:0]     second_q, second_d, second_n;
  logic [HITS_W-1:0] hits_q, hits_d, hits_n;
  logic              out_valid_q, out_valid_d;
  logic [HITS_W-1:0] out_hits_q, out_hits_d;
  logic              full;
  logic              dec_first, dec_second, inc_first, inc_second;
  logic              hit;
  logic              clear;

  assign full = (fill_q == len_i);

  always_comb begin
    dec_first  = 1'b0;
    dec_second = 1'b0;
    if (full) begin
      if (leave_sym_i == cfg_i.first_kind) begin
        dec_first = (first_q != '0);
      end else if (leave_sym_i == cfg_i.second_kind) begin
        dec_second = (second_q != '0);
      end
    end
    inc_first  = (sym_i == cfg_i.first_kind);
    inc_second = !inc_first && (sym_i == cfg_i.second_kind);
  end

  assign first_n  = first_q + LW'(inc_first) - LW'(dec_first);
  assign second_n = second_q + LW'(inc_second) - LW'(dec_second);
  assign fill_n   = full ? fill_q : (fill_q + LW'(1));

  assign hit = (fill_n == len_i)
            && (CW'(first_n) >= CW'(cfg_i.first_min))
            && (CW'(second_n) >= CW'(cfg_i.second_min));

  assign hits_n = (hit && (hits_q != '1)) ? (hits_q + HITS_W'(1)) : hits_q;

  assign clear = cfg_clear_i || (accept_i && last_i);

  always_comb begin
    fill_d   = fill_q;
    first_d  = first_q;
    second_d = second_q;
    hits_d   = hits_q;
    if (clear) begin
      fill_d   = '0;
      first_d  = '0;
      second_d = '0;
      hits_d   = '0;
    end else if (accept_i) begin
      fill_d   = fill_n;
      first_d  = first_n;
      second_d = second_n;
      hits_d   = hits_n;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_hits_d  = out_hits_q;
    if (accept_i && last_i) begin
      out_valid_d = 1'b1;
      out_hits_d  = hits_n;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      first_q     <= '0;
      second_q    <= '0;
      hits_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q      <= fill_d;
      first_q     <= first_d;
      second_q    <= second_d;
      hits_q      <= hits_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_hits_q <= out_hits_d;
  end

  assign out_valid_o   = out_valid_q;
  assign window_hits_o = out_hits_q;

endmodule

// File: tb/tb_window_symbol_quota_counter.sv
// ----------------------------------------------------------------------------
// tb_window_symbol_quota_counter
// Self-checking bench for the sliding-window symbol quota counter. A short
// directed table covers register extremes, short sequences, equal kinds,
// out-of-range codes and restart on register write. Random
// sequences follow under several register settings. Result transfers are
// checked against a cycle-free model of the window tallies, or against the
// fixed values of typed table rows. Both channels see random idle bursts.
// ----------------------------------------------------------------------------
module tb_window_symbol_quota_counter;
  timeunit 1ns;
  timeprecision 1ps;

  import wsqc_pkg::*;

  localparam int unsigned WINDOW_MAX = WINDOW_MAX_DEF;
  localparam int unsigned RAND_ITEMS = 900;
  localparam int unsigned QUIET_TAIL = 150;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_TOP = '1;
  localparam logic [HITS_W-1:0] HITS_MAX = '1;

  typedef struct {
    bit                 is_cfg;
    logic [REG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]   data;
    logic [SYM_W-1:0]   sym;
    bit                 last;
    int unsigned        reps;
    bit                 typed;
    logic [HITS_W-1:0]  hits;
  } plan_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [SYM_W-1:0]     symbol_i = '0;
  logic                 last_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [HITS_W-1:0]    window_hits_o;
  logic                 cfg_we_i = 1'b0;
  logic [REG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0]     cfg_data_i = '0;

  window_symbol_quota_counter DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .symbol_i      (symbol_i),
    .last_i        (last_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .window_hits_o (window_hits_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  // model state
  logic [CFG_W-1:0]  win_len_q;
  logic [SYM_W-1:0]  kind_a_q;
  logic [CFG_W-1:0]  min_a_q;
  logic [SYM_W-1:0]  kind_b_q;
  logic [CFG_W-1:0]  min_b_q;
  logic [SYM_W-1:0]  sym_hist [WINDOW_MAX];
  logic [CFG_W-1:0]  fill_lvl;
  logic [CFG_W-1:0]  tally_a;
  logic [CFG_W-1:0]  tally_b;
  logic [HITS_W-1:0] hit_cnt;

  logic [HITS_W-1:0] pending_hits [$];
  plan_row_t         plan [$];
  int unsigned       errors = 0;
  int unsigned       in_gap_pct = 10;
  int unsigned       stall_pct = 10;
  int unsigned       stall_left = 0;
  bit                quiet = 1'b0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic void clear_sequence();
    foreach (sym_hist[k]) sym_hist[k] = '0;
    fill_lvl = '0;
    tally_a  = '0;
    tally_b  = '0;
    hit_cnt  = '0;
  endfunction

  function automatic logic [CFG_W-1:0] eff_window();
    if (win_len_q == '0) return CFG_W'(1);
    if (win_len_q > CFG_W'(WINDOW_MAX)) return CFG_W'(WINDOW_MAX);
    return win_len_q;
  endfunction

  function automatic void adjust_tally(input logic [SYM_W-1:0] sym, input bit add);
    if (sym == kind_a_q) begin
      if (add) tally_a++;
      else if (tally_a != '0) tally_a--;
    end else if (sym == kind_b_q) begin
      if (add) tally_b++;
      else if (tally_b != '0) tally_b--;
    end
  endfunction

  function automatic void apply_reg(input logic [REG_IDX_W-1:0] idx,
                                    input logic [CFG_W-1:0] data);
    case (idx)
      REG_WINDOW_LEN:  win_len_q = data;
      REG_FIRST_KIND:  kind_a_q  = data[SYM_W-1:0];
      REG_FIRST_MIN:   min_a_q   = data;
      REG_SECOND_KIND: kind_b_q  = data[SYM_W-1:0];
      REG_SECOND_MIN:  min_b_q   = data;
      default: return;
    endcase
    clear_sequence();
  endfunction

  function automatic void advance_windows(input logic [SYM_W-1:0] sym, input bit last,
                                          output bit has_hits,
                                          output logic [HITS_W-1:0] hits);
    logic [CFG_W-1:0] len;
    len = eff_window();
    if (fill_lvl > len) fill_lvl = len;
    if (fill_lvl == len) adjust_tally(sym_hist[len-1], 1'b0);
    for (int k = WINDOW_MAX - 1; k > 0; k--) sym_hist[k] = sym_hist[k-1];
    sym_hist[0] = sym;
    adjust_tally(sym, 1'b1);
    if (fill_lvl < len) fill_lvl++;
    if (fill_lvl == len && tally_a >= min_a_q && tally_b >= min_b_q && hit_cnt != HITS_MAX)
      hit_cnt++;
    has_hits = last;
    hits = hit_cnt;
    if (last) clear_sequence();
  endfunction

  function automatic plan_row_t sym_row(input logic [SYM_W-1:0] sym, input bit last,
                                        input int unsigned reps, input bit typed,
                                        input logic [HITS_W-1:0] hits);
    plan_row_t r;
    r = '{is_cfg: 1'b0, idx: '0, data: '0, sym: sym, last: last, reps: reps,
          typed: typed, hits: hits};
    return r;
  endfunction

  function automatic plan_row_t cfg_row(input logic [REG_IDX_W-1:0] idx,
                                        input logic [CFG_W-1:0] data);
    plan_row_t r;
    r = '{is_cfg: 1'b1, idx: idx, data: data, sym: '0, last: 1'b0, reps: 0,
          typed: 1'b0, hits: '0};
    return r;
  endfunction

  function automatic logic [CFG_W-1:0] rand_kind_data();
    logic [CFG_W-1:0] d;
    d = '0;
    if ($urandom_range(99) < 20) d = CFG_W'($urandom);
    if ($urandom_range(99) < 85) d[SYM_W-1:0] = SYM_W'($urandom_range(0, 4));
    return d;
  endfunction

  function automatic logic [CFG_W-1:0] rand_min_data();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return CFG_W'($urandom_range(0, eff_window() / 2));
    if (r < 80) return '0;
    if (r < 90) return eff_window();
    return CFG_W'($urandom);
  endfunction

  task automatic send_symbol(input logic [SYM_W-1:0] sym, input bit last, input bit typed,
                             input logic [HITS_W-1:0] hits);
    bit got;
    logic [HITS_W-1:0] pred;
    if (!quiet && $urandom_range(99) < in_gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    symbol_i   <= sym;
    last_i     <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    advance_windows(sym, last, got, pred);
    if (got) pending_hits.push_back(typed ? hits : pred);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    settle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    apply_reg(idx, data);
  endtask

  // receiver stall bursts
  always @(posedge clk_i) begin
    if (quiet) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(99) < stall_pct) begin
      out_stall_i <= 1'b1;
      stall_left  <= $urandom_range(0, 16);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin : check_hits
    logic [HITS_W-1:0] want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_hits.size() == 0) begin
        $display("%0t: unexpected transfer, expected none, actual window_hits=%0d",
                 $time, window_hits_o);
        errors++;
      end else begin
        want = pending_hits.pop_front();
        if (window_hits_o !== want) begin
          $display("%0t: window_hits mismatch, expected %0d, actual %0d",
                   $time, want, window_hits_o);
          errors++;
        end
      end
    end
  end

  initial begin
    #4_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    reg_idx_e          order [$];
    int unsigned       rand_items;
    int unsigned       n_seq;
    int unsigned       seq_len;
    int unsigned       r;
    bit                first_phase;
    bit                abort;
    logic [SYM_W-1:0]  sym;
    logic [CFG_W-1:0]  data;

    win_len_q = CFG_W'(1);
    kind_a_q  = SYM_W'(0);
    min_a_q   = '0;
    kind_b_q  = SYM_W'(1);
    min_b_q   = '0;
    clear_sequence();

    plan.push_back(sym_row(3'd0, 1'b1, 1, 1'b1, 16'd1));
    plan.push_back(sym_row(3'd4, 1'b1, 4, 1'b1, 16'd4));
    plan.push_back(cfg_row(REG_WINDOW_LEN, 7'd4));
    plan.push_back(cfg_row(REG_FIRST_KIND, 7'd2));
    plan.push_back(cfg_row(REG_FIRST_MIN, 7'd2));
    plan.push_back(cfg_row(REG_SECOND_KIND, 7'd3));
    plan.push_back(cfg_row(REG_SECOND_MIN, 7'd1));
    // short sequence
    plan.push_back(sym_row(3'd2, 1'b0, 2, 1'b0, '0));
    plan.push_back(sym_row(3'd3, 1'b1, 1, 1'b1, 16'd0));
    plan.push_back(sym_row(3'd2, 1'b0, 2, 1'b0, '0));
    plan.push_back(sym_row(3'd3, 1'b0, 1, 1'b0, '0));
    plan.push_back(sym_row(3'd2, 1'b1, 1, 1'b0, '0));
    // window above max, full-window minimum
    plan.push_back(cfg_row(REG_WINDOW_LEN, 7'h7F));
    plan.push_back(cfg_row(REG_SECOND_MIN, 7'd0));
    plan.push_back(cfg_row(REG_FIRST_MIN, 7'd64));
    plan.push_back(sym_row(3'd2, 1'b1, WINDOW_MAX, 1'b0, '0));
    // equal kinds
    plan.push_back(cfg_row(REG_SECOND_KIND, 7'd2));
    plan.push_back(cfg_row(REG_SECOND_MIN, 7'd1));
    plan.push_back(sym_row(3'd2, 1'b1, WINDOW_MAX, 1'b0, '0));
    // zero window, codes above four
    plan.push_back(cfg_row(REG_WINDOW_LEN, 7'd0));
    plan.push_back(cfg_row(REG_FIRST_KIND, 7'd7));
    plan.push_back(cfg_row(REG_FIRST_MIN, 7'd1));
    plan.push_back(cfg_row(REG_SECOND_KIND, 7'd5));
    plan.push_back(cfg_row(REG_SECOND_MIN, 7'd0));
    plan.push_back(sym_row(3'd7, 1'b1, 1, 1'b0, '0));
    plan.push_back(sym_row(3'd5, 1'b1, 1, 1'b0, '0));
    plan.push_back(sym_row(3'd6, 1'b1, 1, 1'b0, '0));
    // register write restarts an open sequence
    plan.push_back(sym_row(3'd7, 1'b0, 1, 1'b0, '0));
    plan.push_back(cfg_row(REG_FIRST_MIN, 7'd0));
    plan.push_back(sym_row(3'd6, 1'b1, 1, 1'b0, '0));
    plan.push_back(cfg_row(REG_SPARE_TOP, 7'h7F));
    plan.push_back(sym_row(3'd6, 1'b1, 1, 1'b0, '0));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        for (int unsigned n = 1; n <= plan[i].reps; n++)
          send_symbol(plan[i].sym, plan[i].last && n == plan[i].reps, plan[i].typed,
                      plan[i].hits);
      end
    end

    order = '{REG_WINDOW_LEN, REG_FIRST_KIND, REG_FIRST_MIN, REG_SECOND_KIND,
              REG_SECOND_MIN};
    rand_items  = 0;
    first_phase = 1'b1;
    while (rand_items < RAND_ITEMS) begin
      case ($urandom_range(3))
        0: in_gap_pct = 0;
        1: in_gap_pct = 5;
        2: in_gap_pct = 25;
        default: in_gap_pct = 60;
      endcase
      case ($urandom_range(3))
        0: stall_pct = 0;
        1: stall_pct = 5;
        2: stall_pct = 25;
        default: stall_pct = 60;
      endcase
      if (rand_items + QUIET_TAIL >= RAND_ITEMS) quiet = 1'b1;

      order.shuffle();
      foreach (order[j]) begin
        if (first_phase || $urandom_range(99) < 60) begin
          case (order[j])
            REG_WINDOW_LEN: begin
              r = $urandom_range(99);
              if (r < 70) data = CFG_W'($urandom_range(1, 8));
              else if (r < 80) data = '0;
              else if (r < 90) data = CFG_W'($urandom_range(9, WINDOW_MAX));
              else data = CFG_W'($urandom_range(WINDOW_MAX + 1, 127));
            end
            REG_FIRST_KIND, REG_SECOND_KIND: data = rand_kind_data();
            default: data = rand_min_data();
          endcase
          write_reg(order[j], data);
        end
      end
      if ($urandom_range(99) < 10)
        write_reg(REG_IDX_W'($urandom_range(int'(REG_SECOND_MIN) + 1, int'(REG_SPARE_TOP))),
                  CFG_W'($urandom));
      first_phase = 1'b0;

      n_seq = $urandom_range(2, 8);
      for (int unsigned s = 0; s < n_seq && rand_items < RAND_ITEMS; s++) begin
        r = $urandom_range(99);
        if (r < 75) seq_len = $urandom_range(1, 2 * eff_window() + 3);
        else if (r < 85) seq_len = eff_window() - $urandom_range(0, 1);
        else seq_len = $urandom_range(1, 4);
        if (seq_len == 0) seq_len = 1;
        abort = ($urandom_range(99) < 8);
        for (int unsigned i = 0; i < seq_len; i++) begin
          r = $urandom_range(99);
          if (r < 40) sym = kind_a_q;
          else if (r < 70) sym = kind_b_q;
          else if (r < 95) sym = SYM_W'($urandom_range(0, 4));
          else sym = SYM_W'($urandom_range(5, 7));
          send_symbol(sym, (i == seq_len - 1) && !abort, 1'b0, '0);
          rand_items++;
        end
        // broken sequence: rewrite a register to restart it
        if (abort) write_reg(REG_FIRST_MIN, min_a_q);
      end
    end

    settle();
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
